// ----- rtl/core/d2ss_pkg.sv -----
// Shared types, constants and elaboration-time twiddle generation for the
// shifted 2-D spectrum unit. No dependencies.
package d2ss_pkg;

    // Fixed field widths of the item and result words.
    localparam int COORD_W  = 6;
    localparam int SAMPLE_W = 8;
    localparam int OUT_W    = 21;

    // Fixed-point constants used when the twiddle table is built (Q2.30).
    localparam logic [63:0] Q30_ONE = 64'd1 << 30;
    localparam logic [63:0] PI_Q30  = 64'd3373259426;

    // Item kinds.
    typedef enum logic
    {
        KIND_LOAD = 1'b0,
        KIND_READ = 1'b1
    } kind_t;

    // Controller states.
    typedef enum logic [2:0]
    {
        S_IDLE,
        S_RUN,
        S_DRAIN,
        S_MAG,
        S_RND,
        S_OUT
    } ctrl_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed
    {
        logic start;
        logic wr_sample;
        logic issue;
        logic take_mag;
        logic take_rnd;
        logic load_out;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed
    {
        logic last_issue;
        logic pipe_busy;
    } dp_status_t;

    // Restoring long division, used only while the design elaborates.
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [64:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int b = 63; b >= 0; b--)
        begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den})
            begin
                rem    = rem - {1'b0, den};
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Cosine and sine of 2*pi*t/size, rounded to frac fraction bits.
    // Returns {cos, sin}, each a 32-bit two's complement value.
    function automatic logic [63:0] twiddle_pair(input int t, input int size, input int frac);
        logic [63:0] quad;
        logic [63:0] rem;
        logic [63:0] x;
        logic [63:0] ct;
        logic [63:0] st;
        logic [63:0] cm;
        logic [63:0] sm;
        logic [63:0] tmp;
        longint      cs;
        longint      ss;
        logic        neg;
        logic [31:0] c;
        logic [31:0] s;
        logic [31:0] co;
        logic [31:0] si;
        quad = udiv64(64'(4 * t), 64'(size));
        rem  = 64'(4 * t) - quad * 64'(size);
        x    = udiv64(PI_Q30 * rem, 64'(2 * size));
        cs   = longint'(Q30_ONE);
        ss   = longint'(x);
        ct   = Q30_ONE;
        st   = x;
        neg  = 1'b1;
        // Taylor series of both functions on the reduced angle.
        for (int n = 1; n < 40; n = n + 2)
        begin
            ct = (ct * x) >> 30;
            ct = udiv64((ct * x) >> 30, 64'(n * (n + 1)));
            st = (st * x) >> 30;
            st = udiv64((st * x) >> 30, 64'((n + 1) * (n + 2)));
            if (neg)
            begin
                cs = cs - $signed(ct);
                ss = ss - $signed(st);
            end
            else
            begin
                cs = cs + $signed(ct);
                ss = ss + $signed(st);
            end
            neg = !neg;
        end
        cm  = (cs < 0) ? 64'd0 : 64'(cs);
        sm  = (ss < 0) ? 64'd0 : 64'(ss);
        tmp = (cm + (64'd1 << (29 - frac))) >> (30 - frac);
        c   = tmp[31:0];
        tmp = (sm + (64'd1 << (29 - frac))) >> (30 - frac);
        s   = tmp[31:0];
        // Unfold the quadrant.
        case (quad[1:0])
            2'd0:
            begin
                co = c;
                si = s;
            end
            2'd1:
            begin
                co = 32'd0 - s;
                si = c;
            end
            2'd2:
            begin
                co = 32'd0 - c;
                si = 32'd0 - s;
            end
            default:
            begin
                co = s;
                si = 32'd0 - c;
            end
        endcase
        return {co, si};
    endfunction

endpackage

// ----- rtl/core/d2ss_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module d2ss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/core/d2ss_datapath.sv -----
// Datapath of the shifted 2-D spectrum unit: sample store, twiddle tables,
// phase stepping, multiply-accumulate and rounding. Uses d2ss_pkg, d2ss_ram.
module d2ss_datapath #(
    parameter int SIZE              = 64,
    parameter int TWIDDLE_FRAC_BITS = 14
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  d2ss_pkg::ctrl_cmd_t                  cmd,
    output d2ss_pkg::dp_status_t                 stat,
    input  logic [d2ss_pkg::COORD_W-1:0]         col,
    input  logic [d2ss_pkg::COORD_W-1:0]         row,
    input  logic [d2ss_pkg::SAMPLE_W-1:0]        sample,
    output logic signed [d2ss_pkg::OUT_W-1:0]    real_part,
    output logic signed [d2ss_pkg::OUT_W-1:0]    imag_part
);

    localparam int IW      = $clog2(SIZE);
    localparam int N2      = SIZE * SIZE;
    localparam int AW      = $clog2(N2);
    localparam int TW      = TWIDDLE_FRAC_BITS + 2;
    localparam int PW      = d2ss_pkg::SAMPLE_W + 1 + TW;
    localparam int ACCW    = PW + AW;
    localparam int RNDW    = (ACCW + 1 > TWIDDLE_FRAC_BITS + 22) ?
                             ACCW + 1 : TWIDDLE_FRAC_BITS + 22;
    localparam int HALF_UP = SIZE - SIZE / 2;
    localparam int OW      = d2ss_pkg::OUT_W;

    localparam logic [IW:0]     SIZE_W   = (IW + 1)'(SIZE);
    localparam logic [IW:0]     HALF_W   = (IW + 1)'(HALF_UP);
    localparam logic [IW-1:0]   LAST_COL = IW'(SIZE - 1);
    localparam logic [AW-1:0]   SIZE_A   = AW'(SIZE);
    localparam logic [AW-1:0]   LAST_A   = AW'(N2 - 1);
    localparam logic [RNDW-1:0] HALF_R   = RNDW'(1) << (TWIDDLE_FRAC_BITS - 1);
    localparam logic [RNDW-1:0] LIM_POS  = RNDW'(2 ** (OW - 1) - 1);
    localparam logic [RNDW-1:0] LIM_NEG  = RNDW'(2 ** (OW - 1));

    // Constant tables: coordinate reduction, cosine and negated sine.
    logic [IW-1:0]        coord_mod [2 ** d2ss_pkg::COORD_W];
    logic signed [TW-1:0] cos_rom   [SIZE];
    logic signed [TW-1:0] nsin_rom  [SIZE];

    for (genvar g = 0; g < 2 ** d2ss_pkg::COORD_W; g++)
    begin : g_mod
        localparam int MODV = g % SIZE;
        assign coord_mod[g] = MODV[IW-1:0];
    end

    for (genvar g = 0; g < SIZE; g++)
    begin : g_tw
        localparam logic [63:0] TWP   = d2ss_pkg::twiddle_pair(g, SIZE, TWIDDLE_FRAC_BITS);
        localparam logic [31:0] COSV  = TWP[63:32];
        localparam logic [31:0] NSINV = 32'd0 - TWP[31:0];
        assign cos_rom[g]  = COSV[TW-1:0];
        assign nsin_rom[g] = NSINV[TW-1:0];
    end

    // Control registers.
    logic [AW-1:0] addr_reg,      addr_next;
    logic [IW-1:0] col_cnt_reg,   col_cnt_next;
    logic [IW-1:0] phase_reg,     phase_next;
    logic [IW-1:0] row_phase_reg, row_phase_next;
    logic          s1_reg;
    logic          s2_reg;

    // Payload registers.
    logic [IW-1:0]          k_reg;
    logic [IW-1:0]          l_reg;
    logic signed [TW-1:0]   cos_q_reg;
    logic signed [TW-1:0]   nsin_q_reg;
    logic signed [PW-1:0]   prod_re_reg;
    logic signed [PW-1:0]   prod_im_reg;
    logic signed [ACCW-1:0] acc_re_reg;
    logic signed [ACCW-1:0] acc_im_reg;
    logic                   neg_re_reg;
    logic                   neg_im_reg;
    logic [ACCW-1:0]        mag_re_reg;
    logic [ACCW-1:0]        mag_im_reg;
    logic [OW-1:0]          sat_re_reg;
    logic [OW-1:0]          sat_im_reg;
    logic [OW-1:0]          out_re_reg;
    logic [OW-1:0]          out_im_reg;

    logic [IW-1:0]                  col_m;
    logic [IW-1:0]                  row_m;
    logic [AW-1:0]                  wr_addr;
    logic [IW:0]                    k_sum;
    logic [IW:0]                    l_sum;
    logic [IW-1:0]                  k_val;
    logic [IW-1:0]                  l_val;
    logic [IW:0]                    ph_sum;
    logic [IW:0]                    rp_sum;
    logic [IW-1:0]                  ph_wrap;
    logic [IW-1:0]                  rp_wrap;
    logic [d2ss_pkg::SAMPLE_W-1:0]  rd_data;
    logic signed [d2ss_pkg::SAMPLE_W:0] smp_s;
    logic [RNDW-1:0]                rnd_re;
    logic [RNDW-1:0]                rnd_im;
    logic [RNDW-1:0]                lim_re;
    logic [RNDW-1:0]                lim_im;
    logic [RNDW-1:0]                sat_re_w;
    logic [RNDW-1:0]                sat_im_w;

    // Coordinates reduced to the image size, and the store address of a load.
    assign col_m   = coord_mod[col];
    assign row_m   = coord_mod[row];
    assign wr_addr = AW'(row_m) * SIZE_A + AW'(col_m);

    // Display position to frequency pair: add the upper half, wrap once.
    assign k_sum = {1'b0, col_m} + HALF_W;
    assign l_sum = {1'b0, row_m} + HALF_W;
    always_comb
    begin
        k_val = (k_sum >= SIZE_W) ? (k_sum[IW-1:0] - SIZE_W[IW-1:0]) : k_sum[IW-1:0];
        l_val = (l_sum >= SIZE_W) ? (l_sum[IW-1:0] - SIZE_W[IW-1:0]) : l_sum[IW-1:0];
    end

    // Phase stepping: k per column, l per row, all modulo the size.
    assign ph_sum = {1'b0, phase_reg} + {1'b0, k_reg};
    assign rp_sum = {1'b0, row_phase_reg} + {1'b0, l_reg};
    always_comb
    begin
        ph_wrap = (ph_sum >= SIZE_W) ? (ph_sum[IW-1:0] - SIZE_W[IW-1:0]) : ph_sum[IW-1:0];
        rp_wrap = (rp_sum >= SIZE_W) ? (rp_sum[IW-1:0] - SIZE_W[IW-1:0]) : rp_sum[IW-1:0];
    end

    // Next values of the scan counters.
    always_comb
    begin
        addr_next      = addr_reg;
        col_cnt_next   = col_cnt_reg;
        phase_next     = phase_reg;
        row_phase_next = row_phase_reg;
        if (cmd.start)
        begin
            addr_next      = '0;
            col_cnt_next   = '0;
            phase_next     = '0;
            row_phase_next = '0;
        end
        else if (cmd.issue)
        begin
            addr_next = addr_reg + AW'(1);
            if (col_cnt_reg == LAST_COL)
            begin
                col_cnt_next   = '0;
                row_phase_next = rp_wrap;
                phase_next     = rp_wrap;
            end
            else
            begin
                col_cnt_next = col_cnt_reg + IW'(1);
                phase_next   = ph_wrap;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg      <= '0;
            col_cnt_reg   <= '0;
            phase_reg     <= '0;
            row_phase_reg <= '0;
            s1_reg        <= 1'b0;
            s2_reg        <= 1'b0;
        end
        else
        begin
            addr_reg      <= addr_next;
            col_cnt_reg   <= col_cnt_next;
            phase_reg     <= phase_next;
            row_phase_reg <= row_phase_next;
            s1_reg        <= cmd.issue;
            s2_reg        <= s1_reg;
        end
    end

    // Sample store.
    d2ss_ram #(
        .WIDTH (d2ss_pkg::SAMPLE_W),
        .DEPTH (N2)
    ) u_store (
        .clk     (clk),
        .wr_en   (cmd.wr_sample),
        .wr_addr (wr_addr),
        .wr_data (sample),
        .rd_addr (addr_reg),
        .rd_data (rd_data)
    );

    assign smp_s = {1'b0, rd_data};

    // Rounding to integer scale, ties away from zero, then saturation of
    // the magnitude to the bound that matches its sign.
    always_comb
    begin
        rnd_re   = ({{(RNDW - ACCW){1'b0}}, mag_re_reg} + HALF_R) >> TWIDDLE_FRAC_BITS;
        rnd_im   = ({{(RNDW - ACCW){1'b0}}, mag_im_reg} + HALF_R) >> TWIDDLE_FRAC_BITS;
        lim_re   = neg_re_reg ? LIM_NEG : LIM_POS;
        lim_im   = neg_im_reg ? LIM_NEG : LIM_POS;
        sat_re_w = (rnd_re > lim_re) ? lim_re : rnd_re;
        sat_im_w = (rnd_im > lim_im) ? lim_im : rnd_im;
    end

    // Multiply-accumulate pipeline and result stages.
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            k_reg <= k_val;
            l_reg <= l_val;
        end
        cos_q_reg   <= cos_rom[phase_reg];
        nsin_q_reg  <= nsin_rom[phase_reg];
        prod_re_reg <= PW'(smp_s) * PW'(cos_q_reg);
        prod_im_reg <= PW'(smp_s) * PW'(nsin_q_reg);
        if (cmd.start)
        begin
            acc_re_reg <= '0;
            acc_im_reg <= '0;
        end
        else if (s2_reg)
        begin
            acc_re_reg <= acc_re_reg + {{(ACCW - PW){prod_re_reg[PW-1]}}, prod_re_reg};
            acc_im_reg <= acc_im_reg + {{(ACCW - PW){prod_im_reg[PW-1]}}, prod_im_reg};
        end
        if (cmd.take_mag)
        begin
            neg_re_reg <= acc_re_reg[ACCW-1];
            neg_im_reg <= acc_im_reg[ACCW-1];
            mag_re_reg <= acc_re_reg[ACCW-1] ? (ACCW'(0) - acc_re_reg) : acc_re_reg;
            mag_im_reg <= acc_im_reg[ACCW-1] ? (ACCW'(0) - acc_im_reg) : acc_im_reg;
        end
        if (cmd.take_rnd)
        begin
            sat_re_reg <= sat_re_w[OW-1:0];
            sat_im_reg <= sat_im_w[OW-1:0];
        end
        if (cmd.load_out)
        begin
            out_re_reg <= neg_re_reg ? (OW'(0) - sat_re_reg) : sat_re_reg;
            out_im_reg <= neg_im_reg ? (OW'(0) - sat_im_reg) : sat_im_reg;
        end
    end

    assign stat.last_issue = (addr_reg == LAST_A);
    assign stat.pipe_busy  = s1_reg | s2_reg;
    assign real_part       = out_re_reg;
    assign imag_part       = out_im_reg;

endmodule

// ----- rtl/core/d2ss_ctrl.sv -----
// Controller of the shifted 2-D spectrum unit: sequences loads, the scan
// over the store, rounding and the output word. Uses d2ss_pkg.
module d2ss_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 kind,
    output logic                 out_valid,
    input  logic                 out_stall,
    output d2ss_pkg::ctrl_cmd_t  cmd,
    input  d2ss_pkg::dp_status_t stat
);

    d2ss_pkg::ctrl_state_t state_reg, state_next;
    logic                  out_valid_reg, out_valid_next;
    logic                  out_free;
    logic                  is_read;

    assign out_free = !out_valid_reg || !out_stall;
    assign is_read  = (kind == d2ss_pkg::KIND_READ);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            d2ss_pkg::S_IDLE:
            begin
                if (in_valid && is_read)
                begin
                    state_next = d2ss_pkg::S_RUN;
                end
            end
            d2ss_pkg::S_RUN:
            begin
                if (stat.last_issue)
                begin
                    state_next = d2ss_pkg::S_DRAIN;
                end
            end
            d2ss_pkg::S_DRAIN:
            begin
                if (!stat.pipe_busy)
                begin
                    state_next = d2ss_pkg::S_MAG;
                end
            end
            d2ss_pkg::S_MAG:
            begin
                state_next = d2ss_pkg::S_RND;
            end
            d2ss_pkg::S_RND:
            begin
                state_next = d2ss_pkg::S_OUT;
            end
            d2ss_pkg::S_OUT:
            begin
                if (out_free)
                begin
                    state_next = d2ss_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = d2ss_pkg::S_IDLE;
            end
        endcase
    end

    // Commands and input stall.
    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        case (state_reg)
            d2ss_pkg::S_IDLE:
            begin
                in_stall      = 1'b0;
                cmd.start     = in_valid && is_read;
                cmd.wr_sample = in_valid && !is_read;
            end
            d2ss_pkg::S_RUN:
            begin
                cmd.issue = 1'b1;
            end
            d2ss_pkg::S_DRAIN:
            begin
                cmd = '0;
            end
            d2ss_pkg::S_MAG:
            begin
                cmd.take_mag = 1'b1;
            end
            d2ss_pkg::S_RND:
            begin
                cmd.take_rnd = 1'b1;
            end
            d2ss_pkg::S_OUT:
            begin
                cmd.load_out = out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    // Output word valid flag.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= d2ss_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

`ifndef SYNTHESIS
    // A waiting output word is never overwritten.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> !(out_valid_reg && out_stall))
        else $error("output word overwritten while stalled");

    // Rounding starts only once the accumulation pipeline has emptied.
    a_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == d2ss_pkg::S_MAG) |-> !stat.pipe_busy)
        else $error("rounding started with products in flight");

    // An accepted read word starts the scan on the next cycle.
    a_start_scan: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |=> (state_reg == d2ss_pkg::S_RUN))
        else $error("read word did not start the scan");

    // A result word appears only out of the output state.
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == d2ss_pkg::S_OUT))
        else $error("output word raised outside the output state");
`endif

endmodule

// ----- rtl/core/dft2d_shifted_spectrum_unit.sv -----
// Top level of the shifted 2-D spectrum unit: joins the controller and
// the datapath. Uses d2ss_pkg, d2ss_ctrl, d2ss_datapath.
//
// Usage: the input channel (in_valid, in_stall) takes one word per accepted
// cycle. A word with kind low loads sample into the store at (col, row);
// a word with kind high reads the spectrum bin shown at display position
// (col, row), with the zero frequency in the centre. The output channel
// (out_valid, out_stall) returns real_part and imag_part for each read and
// nothing for a load.
// Loads may follow back to back.
// A read steps through all SIZE*SIZE stored samples, one multiply-
// accumulate per cycle through the single read port of the sample store;
// its result follows the scan, pipeline drain, magnitude and rounding
// steps, and no new word is taken until that result has been loaded.
// Reset clears the controller and the scan counters; the sample store is
// undefined until written; load each sample before a read (not enforced).
// A stalled result word holds in the output register while the next read
// is computed; that read then waits until the word is taken.
module dft2d_shifted_spectrum_unit #(
    parameter int SIZE              = 64,
    parameter int TWIDDLE_FRAC_BITS = 14
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic                                 kind,
    input  logic [d2ss_pkg::COORD_W-1:0]         col,
    input  logic [d2ss_pkg::COORD_W-1:0]         row,
    input  logic [d2ss_pkg::SAMPLE_W-1:0]        sample,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [d2ss_pkg::OUT_W-1:0]    real_part,
    output logic signed [d2ss_pkg::OUT_W-1:0]    imag_part
);

    d2ss_pkg::ctrl_cmd_t  cmd;
    d2ss_pkg::dp_status_t stat;

    // Sequencing.
    d2ss_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .kind      (kind),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .stat      (stat)
    );

    // Store, twiddles and arithmetic.
    d2ss_datapath #(
        .SIZE              (SIZE),
        .TWIDDLE_FRAC_BITS (TWIDDLE_FRAC_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .col       (col),
        .row       (row),
        .sample    (sample),
        .real_part (real_part),
        .imag_part (imag_part)
    );

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for the shifted 2-D spectrum unit. It loads gray images, reads
// shifted bins and checks each result word against a bit-exact fixed-point predictor.
// Depends on d2ss_pkg and dft2d_shifted_spectrum_unit.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COORD_W     = d2ss_pkg::COORD_W;
    localparam int SAMPLE_W    = d2ss_pkg::SAMPLE_W;
    localparam int OUT_W       = d2ss_pkg::OUT_W;
    localparam int N           = 64;
    localparam int FRAC_BITS   = 14;
    localparam int HOLD_CYCLES = 12000;
    localparam int HOLD_AT_BIN = 12;
    localparam int RANDOM_WORDS = 140;
    localparam int CALM_WORDS   = 20;
    localparam int QUIET_LIMIT  = 4 * (HOLD_CYCLES + N * N);
    localparam longint unsigned ONE_Q2_30 = 64'd1 << 30;
    localparam longint unsigned PI_Q2_30  = 64'd3373259426;
    localparam longint BIN_MAX = 1048575;
    localparam longint BIN_MIN = -1048576;

    typedef struct {
        d2ss_pkg::kind_t       op;
        logic [COORD_W-1:0]    col;
        logic [COORD_W-1:0]    row;
        logic [SAMPLE_W-1:0]   value;
        bit                    calm;
    } word_t;

    typedef struct {
        logic signed [OUT_W-1:0] re;
        logic signed [OUT_W-1:0] im;
    } spectrum_bin_t;

    logic                       clk       = 1'b0;
    logic                       rst_n     = 1'b0;
    logic                       in_valid  = 1'b0;
    logic                       in_stall;
    logic                       kind      = d2ss_pkg::KIND_LOAD;
    logic [COORD_W-1:0]         col       = '0;
    logic [COORD_W-1:0]         row       = '0;
    logic [SAMPLE_W-1:0]        sample    = '0;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic signed [OUT_W-1:0]    real_part;
    logic signed [OUT_W-1:0]    imag_part;

    // Twiddle tables and the predictor's own copy of the image.
    int                  cos_lut [N];
    int                  sin_lut [N];
    logic [SAMPLE_W-1:0] pixel_mem [N * N];

    word_t         words_pending [$];
    spectrum_bin_t bins_due [$];

    int words_queued = 0;
    int words_taken  = 0;
    int loads_taken  = 0;
    int reads_taken  = 0;
    int bins_seen    = 0;
    int mismatches   = 0;
    int quiet        = 0;
    int hold_left    = 0;
    bit hold_done    = 1'b0;
    bit tail_calm    = 1'b0;
    int src_burst    = 0;
    int src_calm     = 0;
    int snk_burst    = 0;
    int snk_calm     = 0;

    dft2d_shifted_spectrum_unit #(
        .SIZE              (N),
        .TWIDDLE_FRAC_BITS (FRAC_BITS)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .kind      (kind),
        .col       (col),
        .row       (row),
        .sample    (sample),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .real_part (real_part),
        .imag_part (imag_part)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // Random idling in short bursts, with occasional stretches free of idling.
    function automatic bit pick_idle(inout int burst, inout int calm);
        if (burst > 0)
        begin
            burst--;
            return 1'b1;
        end
        if (calm > 0)
        begin
            calm--;
            return 1'b0;
        end
        case ($urandom_range(0, 11))
            0, 1, 2:
            begin
                burst = $urandom_range(0, 6);
                return 1'b1;
            end
            3:
            begin
                calm = $urandom_range(20, 80);
                return 1'b0;
            end
            default:
                return 1'b0;
        endcase
    endfunction

    // Round an exact sum to integer scale, ties away from zero, then saturate.
    function automatic logic signed [OUT_W-1:0] round_to_field(input longint acc);
        longint unsigned mag;
        longint          val;
        mag = (acc < 0) ? -acc : acc;
        mag = (mag + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        if (mag > (64'd1 << 40))
            mag = 64'd1 << 40;
        val = (acc < 0) ? -signed'(mag) : signed'(mag);
        if (val > BIN_MAX)
            val = BIN_MAX;
        if (val < BIN_MIN)
            val = BIN_MIN;
        return val[OUT_W-1:0];
    endfunction

    // Spectrum bin at a display position, with the zero frequency in the centre.
    function automatic spectrum_bin_t shifted_bin(input logic [COORD_W-1:0] dcol,
                                                  input logic [COORD_W-1:0] drow);
        spectrum_bin_t bin;
        int            kf;
        int            lf;
        int            tw;
        longint        acc_re;
        longint        acc_im;
        longint        px;
        kf     = (int'(dcol) + N - N / 2) % N;
        lf     = (int'(drow) + N - N / 2) % N;
        acc_re = 0;
        acc_im = 0;
        for (int j = 0; j < N; j++)
        begin
            for (int i = 0; i < N; i++)
            begin
                px     = pixel_mem[j * N + i];
                tw     = (kf * i + lf * j) % N;
                acc_re = acc_re + px * cos_lut[tw];
                acc_im = acc_im - px * sin_lut[tw];
            end
        end
        bin.re = round_to_field(acc_re);
        bin.im = round_to_field(acc_im);
        return bin;
    endfunction

    // Twiddle tables: quadrant reduction, then a Taylor series in Q2.30, rounded.
    initial
    begin : twiddle_tables
        longint unsigned quad;
        longint unsigned rem;
        longint unsigned ang;
        longint unsigned ct;
        longint unsigned st;
        longint unsigned cmag;
        longint unsigned smag;
        longint          csum;
        longint          ssum;
        bit              neg;
        int              c;
        int              s;
        for (int t = 0; t < N; t++)
        begin
            quad = (4 * t) / N;
            rem  = 4 * t - quad * N;
            ang  = (PI_Q2_30 * rem) / (2 * N);
            csum = ONE_Q2_30;
            ssum = ang;
            ct   = ONE_Q2_30;
            st   = ang;
            neg  = 1'b1;
            for (int n = 1; n < 40; n += 2)
            begin
                ct = (ct * ang) >> 30;
                ct = ((ct * ang) >> 30) / (n * (n + 1));
                st = (st * ang) >> 30;
                st = ((st * ang) >> 30) / ((n + 1) * (n + 2));
                if (neg)
                begin
                    csum = csum - signed'(ct);
                    ssum = ssum - signed'(st);
                end
                else
                begin
                    csum = csum + signed'(ct);
                    ssum = ssum + signed'(st);
                end
                neg = !neg;
            end
            cmag = (csum < 0) ? 64'd0 : csum;
            smag = (ssum < 0) ? 64'd0 : ssum;
            c    = int'((cmag + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS));
            s    = int'((smag + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS));
            case (quad & 3)
                0:
                begin
                    cos_lut[t] = c;
                    sin_lut[t] = s;
                end
                1:
                begin
                    cos_lut[t] = -s;
                    sin_lut[t] = c;
                end
                2:
                begin
                    cos_lut[t] = -c;
                    sin_lut[t] = -s;
                end
                default:
                begin
                    cos_lut[t] = s;
                    sin_lut[t] = -c;
                end
            endcase
        end
    end

    // Input driver: predicts reads, records loads, then offers the next word or idles.
    always @(posedge clk)
    begin : drive_words
        word_t nxt;
        bit    idle;
        if (in_valid && !in_stall)
        begin
            if (kind == d2ss_pkg::KIND_READ)
            begin
                bins_due.push_back(shifted_bin(col, row));
                reads_taken++;
            end
            else
            begin
                pixel_mem[row * N + col] = sample;
                loads_taken++;
            end
            words_taken <= words_taken + 1;
        end
        if (!(in_valid && in_stall))
        begin
            idle = tail_calm ? 1'b0 : pick_idle(src_burst, src_calm);
            if (!idle && words_pending.size() != 0)
            begin
                nxt = words_pending.pop_front();
                kind     <= nxt.op;
                col      <= nxt.col;
                row      <= nxt.row;
                sample   <= nxt.value;
                in_valid <= 1'b1;
                if (nxt.calm)
                    tail_calm <= 1'b1;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Result monitor: compares each accepted word with the oldest predicted bin.
    always @(posedge clk)
    begin : check_bins
        spectrum_bin_t due;
        if (out_valid && !out_stall)
        begin
            if (bins_due.size() == 0)
            begin
                $display("%0t: result word with no read pending, real %0d imag %0d",
                         $time, real_part, imag_part);
                mismatches++;
            end
            else
            begin
                due = bins_due.pop_front();
                if (real_part !== due.re)
                begin
                    $display("%0t: real_part expected %0d, actual %0d",
                             $time, due.re, real_part);
                    mismatches++;
                end
                if (imag_part !== due.im)
                begin
                    $display("%0t: imag_part expected %0d, actual %0d",
                             $time, due.im, imag_part);
                    mismatches++;
                end
            end
            bins_seen <= bins_seen + 1;
        end
    end

    // Receiver stall: one long hold-off while the sender keeps offering, so that the
    // input backs up, and random idling otherwise.
    always @(posedge clk)
    begin : sink_stall
        if (hold_left != 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (!hold_done && bins_seen == HOLD_AT_BIN)
        begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= tail_calm ? 1'b0 : pick_idle(snk_burst, snk_calm);
        end
    end

    // Watchdog on cycles in which no word moves on either side.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            quiet <= 0;
        end
        else if (quiet == QUIET_LIMIT)
        begin
            $display("%0t: no word moved for %0d cycles", $time, QUIET_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end
        else
        begin
            quiet <= quiet + 1;
        end
    end

    task automatic queue_word(input d2ss_pkg::kind_t op, input int c, input int r,
                              input int v, input bit calm);
        word_t w;
        w.op    = op;
        w.col   = COORD_W'(c);
        w.row   = COORD_W'(r);
        w.value = SAMPLE_W'(v);
        w.calm  = calm;
        words_pending.push_back(w);
        words_queued++;
    endtask

    // Load every pixel, either flat full scale or random.
    task automatic fill_image(input bit noisy);
        for (int r = 0; r < N; r++)
        begin
            for (int c = 0; c < N; c++)
            begin
                queue_word(d2ss_pkg::KIND_LOAD, c, r,
                           noisy ? $urandom_range(0, 255) : 255, 1'b0);
            end
        end
    endtask

    // The sender pauses until every word is taken and every bin has come back.
    task automatic wait_drained();
        @(negedge clk);
        while (words_taken != words_queued || bins_due.size() != 0)
            @(negedge clk);
    endtask

    initial
    begin : stimulus
        int v;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Flat full-scale image: largest DC sum, corners, Nyquist bin.
        fill_image(1'b0);
        queue_word(d2ss_pkg::KIND_READ, N / 2, N / 2, 0, 1'b0);
        queue_word(d2ss_pkg::KIND_READ, 0, 0, 255, 1'b0);
        queue_word(d2ss_pkg::KIND_READ, N - 1, 0, 0, 1'b0);
        queue_word(d2ss_pkg::KIND_READ, N / 2 + 1, N / 2, 0, 1'b0);
        wait_drained();

        // Random image with extreme pixels at the corners and an overwritten pixel.
        fill_image(1'b1);
        queue_word(d2ss_pkg::KIND_LOAD, 0, 0, 0, 1'b0);
        queue_word(d2ss_pkg::KIND_LOAD, N - 1, N - 1, 255, 1'b0);
        queue_word(d2ss_pkg::KIND_LOAD, N - 1, 0, 8'hAA, 1'b0);
        queue_word(d2ss_pkg::KIND_LOAD, 0, N - 1, 8'h55, 1'b0);
        queue_word(d2ss_pkg::KIND_LOAD, 5, 7, 1, 1'b0);
        queue_word(d2ss_pkg::KIND_LOAD, 5, 7, 200, 1'b0);
        queue_word(d2ss_pkg::KIND_READ, N / 2, N / 2, 0, 1'b0);
        queue_word(d2ss_pkg::KIND_READ, 0, 0, 0, 1'b0);
        queue_word(d2ss_pkg::KIND_READ, N - 1, N - 1, 255, 1'b0);
        queue_word(d2ss_pkg::KIND_READ, N / 2 + 1, N / 2 - 1, 0, 1'b0);
        queue_word(d2ss_pkg::KIND_READ, N / 2 - 1, N / 2 + 1, 0, 1'b0);
        queue_word(d2ss_pkg::KIND_READ, 0, N / 2, 0, 1'b0);
        wait_drained();

        // Random mix of pixel updates and bin reads; the tail runs without idling.
        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            case ($urandom_range(0, 7))
                0:       v = 0;
                1:       v = 255;
                default: v = $urandom_range(0, 255);
            endcase
            if ($urandom_range(0, 9) < 4)
                queue_word(d2ss_pkg::KIND_READ, $urandom_range(0, N - 1),
                           $urandom_range(0, N - 1), v, n >= RANDOM_WORDS - CALM_WORDS);
            else
                queue_word(d2ss_pkg::KIND_LOAD, $urandom_range(0, N - 1),
                           $urandom_range(0, N - 1), v, n >= RANDOM_WORDS - CALM_WORDS);
        end
        wait_drained();

        // Let any stray result word surface before the verdict.
        repeat (N * N + 16) @(posedge clk);
        @(negedge clk);
        $display("Covered %0d sample loads and %0d bin reads on two full images and a mix,",
                 loads_taken, reads_taken);
        $display("%0d result words compared, %0d mismatching fields.", bins_seen, mismatches);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
